>>> hdl/rmit_pkg.sv
// ----------------------------------------------------------------------------
// rmit_pkg
// Shared types, constants and helper functions for the range maximum index
// tree: node entry layout, memory request bundle and winner selection.
// ----------------------------------------------------------------------------
package rmit_pkg;

  localparam int NUM_ELEMENTS = 1024;
  localparam int IDX_W        = $clog2(NUM_ELEMENTS);
  localparam int NODE_W       = IDX_W + 1;
  localparam int QRY_W        = NODE_W + 1;
  localparam int NODE_DEPTH   = 2 * NUM_ELEMENTS;
  localparam int VAL_W        = 32;
  localparam int ENTRY_W      = IDX_W + VAL_W;
  localparam int LVL_W        = $clog2(NODE_W);

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef struct packed {
    logic        [IDX_W-1:0] idx;
    logic signed [VAL_W-1:0] val;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    entry_t            wdata;
    logic [NODE_W-1:0] raddr_a;
    logic [NODE_W-1:0] raddr_b;
  } mem_req_t;

  // larger value wins, lower index on equal values
  function automatic logic beats(entry_t a, entry_t b);
    logic gt;
    logic eq;
    gt = $signed(a.val) > $signed(b.val);
    eq = a.val == b.val;
    return gt || (eq && (a.idx <= b.idx));
  endfunction

  // first element index covered by heap node k
  function automatic logic [IDX_W-1:0] range_start(logic [NODE_W-1:0] k);
    logic [LVL_W-1:0]  lvl;
    logic [LVL_W-1:0]  sh;
    logic [NODE_W-1:0] tmp;
    lvl = '0;
    for (int p = 0; p < NODE_W; p++) begin
      if (k[p]) begin
        lvl = LVL_W'(p);
      end
    end
    sh  = LVL_W'(IDX_W) - lvl;
    tmp = k << sh;
    return tmp[IDX_W-1:0];
  endfunction

endpackage

>>> hdl/rmit_ifs.sv
// ----------------------------------------------------------------------------
// rmit_ifs
// Valid/ready channel interfaces for request and response transactions.
// ----------------------------------------------------------------------------
interface rmit_req_if;
  import rmit_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic        [IDX_W-1:0] position;
  logic signed [VAL_W-1:0] new_value;
  logic        [IDX_W-1:0] range_left;
  logic        [IDX_W-1:0] range_right;

  modport source (output valid, opcode, position, new_value, range_left, range_right,
                  input ready);
  modport sink   (input valid, opcode, position, new_value, range_left, range_right,
                  output ready);
endinterface

interface rmit_rsp_if;
  import rmit_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] max_position;
  logic             empty_res;

  modport source (output valid, max_position, empty_res, input ready);
  modport sink   (input valid, max_position, empty_res, output ready);
endinterface

>>> hdl/rmit_ram.sv
// ----------------------------------------------------------------------------
// rmit_ram
// Generic synchronous RAM, one write port and two read ports, registered
// read data.
// ----------------------------------------------------------------------------
module rmit_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 2048,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hdl/rmit_walker.sv
// ----------------------------------------------------------------------------
// rmit_walker
// Tree walk sequencer: clearing pass, leaf-to-root update and bottom-up range
// query over the node memory, with the response register.
// ----------------------------------------------------------------------------
module rmit_walker (
  input  logic              clk,
  input  logic              rst,
  rmit_req_if.sink          req,
  rmit_rsp_if.source        rsp,
  output rmit_pkg::mem_req_t mem,
  input  rmit_pkg::entry_t  rd_a,
  input  rmit_pkg::entry_t  rd_b
);
  import rmit_pkg::*;

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    UPD,
    QRY,
    FIN
  } state_t;

  state_t            state;
  logic [NODE_W-1:0] clr_cnt;
  logic [NODE_W-1:0] node;
  entry_t            acc;
  logic [QRY_W-1:0]  ql;
  logic [QRY_W-1:0]  qr;
  logic              take_l;
  logic              take_r;
  logic              pend;
  entry_t            best;
  logic              best_valid;
  logic              out_valid;
  logic [IDX_W-1:0]  out_pos;
  logic              out_empty;

  entry_t            upd_win;
  logic [NODE_W-1:0] parent;
  entry_t            cand;
  logic              cand_v;
  logic              accept;
  logic              out_free;

  assign req.ready        = (state == IDLE);
  assign accept           = req.valid && req.ready;
  assign rsp.valid        = out_valid;
  assign rsp.max_position = out_pos;
  assign rsp.empty_res    = out_empty;
  assign out_free         = !out_valid || rsp.ready;

  assign upd_win = beats(acc, rd_a) ? acc : rd_a;
  assign parent  = {1'b0, node[NODE_W-1:1]};

  always_comb begin
    cand   = rd_a;
    cand_v = 1'b0;
    if (pend) begin
      if (take_l && take_r) begin
        cand   = beats(rd_a, rd_b) ? rd_a : rd_b;
        cand_v = 1'b1;
      end else if (take_l) begin
        cand   = rd_a;
        cand_v = 1'b1;
      end else if (take_r) begin
        cand   = rd_b;
        cand_v = 1'b1;
      end
    end
  end

  always_comb begin
    mem = '0;
    case (state)
      CLEAR: begin
        mem.we        = 1'b1;
        mem.waddr     = clr_cnt;
        mem.wdata.idx = range_start(clr_cnt);
        mem.wdata.val = '0;
      end
      IDLE: begin
        if (req.valid && req.opcode == OP_UPDATE) begin
          mem.we        = 1'b1;
          mem.waddr     = {1'b1, req.position};
          mem.wdata.idx = req.position;
          mem.wdata.val = req.new_value;
          mem.raddr_a   = {1'b1, req.position[IDX_W-1:1], ~req.position[0]};
        end
      end
      UPD: begin
        mem.we      = 1'b1;
        mem.waddr   = parent;
        mem.wdata   = upd_win;
        mem.raddr_a = {parent[NODE_W-1:1], ~parent[0]};
      end
      QRY: begin
        mem.raddr_a = ql[NODE_W-1:0];
        mem.raddr_b = qr[NODE_W-1:0];
      end
      default: begin
        mem = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (accept) begin
            if (req.opcode == OP_UPDATE) begin
              node       <= {1'b1, req.position};
              acc.idx    <= req.position;
              acc.val    <= req.new_value;
              state      <= UPD;
            end else begin
              ql         <= {2'b01, req.range_left};
              qr         <= {2'b01, req.range_right};
              best_valid <= 1'b0;
              pend       <= 1'b0;
              state      <= (req.range_left > req.range_right) ? FIN : QRY;
            end
          end
        end
        UPD: begin
          acc  <= upd_win;
          node <= parent;
          if (parent == NODE_W'(1)) begin
            state <= IDLE;
          end
        end
        QRY: begin
          if (cand_v && (!best_valid || beats(cand, best))) begin
            best       <= cand;
            best_valid <= 1'b1;
          end
          if (ql <= qr) begin
            take_l <= ql[0];
            take_r <= ~qr[0];
            ql     <= (ql + QRY_W'(ql[0])) >> 1;
            qr     <= (qr - QRY_W'(!qr[0])) >> 1;
            pend   <= 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= FIN;
          end
        end
        FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_pos   <= best_valid ? best.idx : '0;
            out_empty <= ~best_valid;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_no_write_in_query: assert property (@(posedge clk) disable iff (rst)
    (state == QRY) |-> !mem.we)
    else $error("node memory written during a query walk");

  a_upd_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == UPD) |-> (mem.waddr != mem.raddr_a))
    else $error("update reads the node it writes");

  a_update_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && req.opcode == OP_UPDATE) |=> (state == UPD))
    else $error("accepted update did not start its walk");

  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == FIN))
    else $error("response raised outside the finish step");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == CLEAR) |-> !req.ready)
    else $error("transaction accepted during the clearing pass");

endmodule

>>> hdl/range_max_index_tree.sv
// ----------------------------------------------------------------------------
// range_max_index_tree
// Segment tree of winner entries (index and value) in one node memory with
// a leaf-to-root update walk and a bottom-up range query walk.
// ----------------------------------------------------------------------------
// update: a leaf-to-root walk, one tree level per cycle on the node memory port
// query: two node reads per level; an empty range goes straight to the finish
// step
// a new transaction is taken while a finished response still waits
// reset: a clearing pass writes every node before input
// is accepted; the response channel is idle after reset
module range_max_index_tree (
  input  logic       clk,
  input  logic       rst,
  rmit_req_if.sink   req,
  rmit_rsp_if.source rsp
);
  import rmit_pkg::*;

  mem_req_t mem;
  entry_t   rd_a;
  entry_t   rd_b;

  rmit_walker u_walker (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .mem  (mem),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  rmit_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (mem.we),
    .waddr   (mem.waddr),
    .wdata   (mem.wdata),
    .raddr_a (mem.raddr_a),
    .raddr_b (mem.raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

endmodule

>>> tb/range_max_index_tree_tb.sv
// ----------------------------------------------------------------------------
// range_max_index_tree_tb
// Self-checking bench for the range maximum index tree. Element writes and
// range queries go in through the request channel and are mirrored in a
// local array. Each query is answered by a scan for the largest value,
// lowest index first. Responses are compared in order, with random idle
// bursts on both channels.
// ----------------------------------------------------------------------------
module range_max_index_tree_tb;
  import rmit_pkg::*;

  typedef struct {
    op_t                     opcode;
    logic        [IDX_W-1:0] position;
    logic signed [VAL_W-1:0] new_value;
    logic        [IDX_W-1:0] range_left;
    logic        [IDX_W-1:0] range_right;
    bit                      drain_first;
  } tree_op_t;

  typedef struct {
    logic [IDX_W-1:0] max_position;
    logic             empty_res;
  } max_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmit_req_if req();
  rmit_rsp_if rsp();

  range_max_index_tree uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #1 clk = ~clk;

  tree_op_t                pending_ops[$];
  max_result_t             expected_max[$];
  logic signed [VAL_W-1:0] elem_value[NUM_ELEMENTS];

  bit req_fire;
  int idle_left;
  int stall_left;
  int failures;
  int n_updates;
  int n_queries;
  int n_empty;
  int n_checked;

  function automatic void push_update(int pos, logic signed [VAL_W-1:0] val);
    tree_op_t op;
    op.opcode      = OP_UPDATE;
    op.position    = IDX_W'(pos);
    op.new_value   = val;
    op.range_left  = IDX_W'($urandom);
    op.range_right = IDX_W'($urandom);
    op.drain_first = 1'b0;
    pending_ops.push_back(op);
  endfunction

  function automatic void push_query(int lo, int hi);
    tree_op_t op;
    op.opcode      = OP_QUERY;
    op.position    = IDX_W'($urandom);
    op.new_value   = $urandom;
    op.range_left  = IDX_W'(lo);
    op.range_right = IDX_W'(hi);
    op.drain_first = 1'b0;
    pending_ops.push_back(op);
  endfunction

  function automatic logic signed [VAL_W-1:0] random_value();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0, 1: return VAL_W'($signed($urandom_range(0, 4)) - 2);
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_random_query();
    int sel;
    int lo;
    int hi;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      lo = $urandom_range(1, NUM_ELEMENTS - 1);
      push_query(lo, $urandom_range(0, lo - 1));
    end else if (sel == 1) begin
      push_query(0, NUM_ELEMENTS - 1);
    end else begin
      lo = $urandom_range(0, NUM_ELEMENTS - 1);
      hi = lo + ((sel < 6) ? $urandom_range(0, 15) : $urandom_range(0, NUM_ELEMENTS - 1));
      if (hi > NUM_ELEMENTS - 1) begin
        hi = NUM_ELEMENTS - 1;
      end
      push_query(lo, hi);
    end
  endfunction

  // largest value in [lo, hi], lowest index on ties
  function automatic max_result_t range_argmax(logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
    max_result_t res;
    int          last;
    int          best;
    res.max_position = '0;
    res.empty_res    = 1'b1;
    last = int'(hi);
    if (last > NUM_ELEMENTS - 1) begin
      last = NUM_ELEMENTS - 1;
    end
    if (int'(lo) <= last) begin
      best = int'(lo);
      for (int k = int'(lo) + 1; k <= last; k++) begin
        if (elem_value[k] > elem_value[best]) begin
          best = k;
        end
      end
      res.max_position = IDX_W'(best);
      res.empty_res    = 1'b0;
    end
    return res;
  endfunction

  function automatic void predict_transaction();
    if (req.opcode == OP_UPDATE) begin
      n_updates++;
      if (int'(req.position) < NUM_ELEMENTS) begin
        elem_value[req.position] = req.new_value;
      end
    end else begin
      n_queries++;
      expected_max.push_back(range_argmax(req.range_left, req.range_right));
    end
  endfunction

  function automatic void check_response();
    max_result_t exp;
    if (expected_max.size() == 0) begin
      $error("unexpected response: max_position %0d empty_res %0d",
             rsp.max_position, rsp.empty_res);
      failures++;
    end else begin
      exp = expected_max.pop_front();
      n_checked++;
      if (exp.empty_res) begin
        n_empty++;
      end
      if (rsp.empty_res !== exp.empty_res) begin
        $error("empty_res: expected %0d, got %0d", exp.empty_res, rsp.empty_res);
        failures++;
      end
      if (rsp.max_position !== exp.max_position) begin
        $error("max_position: expected %0d, got %0d", exp.max_position, rsp.max_position);
        failures++;
      end
    end
  endfunction

  // sample both channels
  always @(posedge clk) begin
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req.valid && req.ready;
      if (req.valid && req.ready) begin
        predict_transaction();
      end
      if (rsp.valid && rsp.ready) begin
        check_response();
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    tree_op_t op;
    bit       quiet;
    if (rst) begin
      req.valid <= 1'b0;
      idle_left = 0;
    end else if (!req.valid || req_fire) begin
      quiet = (pending_ops.size() < 150) || (((n_updates + n_queries) / 128) % 4 == 3);
      if (idle_left > 0) begin
        idle_left--;
        req.valid <= 1'b0;
      end else if (pending_ops.size() == 0 ||
                   (pending_ops[0].drain_first && expected_max.size() != 0)) begin
        req.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        idle_left = $urandom_range(1, 17) - 1;
        req.valid <= 1'b0;
      end else begin
        op = pending_ops.pop_front();
        req.valid       <= 1'b1;
        req.opcode      <= op.opcode;
        req.position    <= op.position;
        req.new_value   <= op.new_value;
        req.range_left  <= op.range_left;
        req.range_right <= op.range_right;
      end
    end
  end

  // response back-pressure
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else if (pending_ops.size() >= 150 && (n_checked / 96) % 4 != 1 &&
                 $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  initial begin
    req.valid       = 1'b0;
    req.opcode      = OP_UPDATE;
    req.position    = '0;
    req.new_value   = '0;
    req.range_left  = '0;
    req.range_right = '0;
    rsp.ready       = 1'b0;
    failures  = 0;
    n_updates = 0;
    n_queries = 0;
    n_empty   = 0;
    n_checked = 0;
    for (int k = 0; k < NUM_ELEMENTS; k++) begin
      elem_value[k] = '0;
    end

    // directed: reset contents, extremes, ties, empty ranges, unused fields
    push_query(0, NUM_ELEMENTS - 1);
    push_query(5, 5);
    push_query(10, 3);
    push_query(NUM_ELEMENTS - 1, NUM_ELEMENTS - 1);
    push_update(0, 32'sh80000000);
    push_update(NUM_ELEMENTS - 1, 32'sh7fffffff);
    push_query(0, NUM_ELEMENTS - 1);
    push_query(0, NUM_ELEMENTS - 2);
    push_update(512, 32'sh7fffffff);
    push_query(0, NUM_ELEMENTS - 1);
    pending_ops[$].drain_first = 1'b1;
    push_query(513, NUM_ELEMENTS - 1);
    push_update(NUM_ELEMENTS - 1, -32'sd1);
    push_query(1000, NUM_ELEMENTS - 1);
    push_update(0, 32'sh7fffffff);
    push_query(0, NUM_ELEMENTS - 1);
    push_query(1, 0);
    push_update(300, 32'sd5);
    pending_ops[$].range_left  = '1;
    pending_ops[$].range_right = '0;
    push_query(200, 400);
    pending_ops[$].position  = '1;
    pending_ops[$].new_value = '1;
    push_query(NUM_ELEMENTS - 1, 0);
    pending_ops[$].position = '1;
    push_update(511, 32'sh80000000);
    push_query(511, 511);
    push_query(0, 0);

    // random mix of writes and range queries
    for (int n = 0; n < 1450; n++) begin
      if ($urandom_range(0, 99) < 45) begin
        push_update($urandom_range(0, NUM_ELEMENTS - 1), random_value());
      end else begin
        push_random_query();
      end
      if (n % 350 == 175) begin
        pending_ops[$].drain_first = 1'b1;
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || req.valid) begin
      @(posedge clk);
    end
    while (expected_max.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (expected_max.size() != 0) begin
      $error("%0d responses never arrived", expected_max.size());
      failures++;
    end
    $display("covered %0d element writes and %0d range queries", n_updates, n_queries);
    $display("%0d responses checked, %0d of them empty ranges", n_checked, n_empty);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
hdl/rmit_pkg.sv
hdl/rmit_ifs.sv
hdl/rmit_ram.sv
hdl/rmit_walker.sv
hdl/range_max_index_tree.sv
tb/range_max_index_tree_tb.sv
